>>> rtl/stable_descending_record_sorter_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the record sorter
// Shared property shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_DESCENDING_RECORD_SORTER_UNIT_DEFINES_SVH
`define STABLE_DESCENDING_RECORD_SORTER_UNIT_DEFINES_SVH

// Same-cycle implication
`define SDRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SDRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sdrs_pkg.sv
// ----------------------------------------------------------------------------
// sdrs_pkg
// Widths, record and control types shared by the record sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdrs_pkg;

  localparam int CAPACITY = 32;
  localparam int KEY_BITS = 10;
  localparam int TAG_BITS = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [KEY_BITS-1:0] rating;
  } rec_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic ins;    // insert new_rec into the chain
    logic shift;  // move every record one cell toward the head
    rec_t new_rec;
  } ctl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

endpackage

`default_nettype wire

>>> rtl/sdrs_in_if.sv
// ----------------------------------------------------------------------------
// sdrs_in_if
// Input channel of the record sorter: valid/ready plus one record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sdrs_in_if;
  logic                          valid;
  logic                          ready;
  logic [sdrs_pkg::TAG_BITS-1:0] record_tag;
  logic [sdrs_pkg::KEY_BITS-1:0] rating_key;
  logic                          last_in;

  modport source (output valid, output record_tag, output rating_key, output last_in,
                  input ready);
  modport sink   (input valid, input record_tag, input rating_key, input last_in,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/sdrs_out_if.sv
// ----------------------------------------------------------------------------
// sdrs_out_if
// Output channel of the record sorter: valid/ready plus one sorted record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sdrs_out_if;
  logic                          valid;
  logic                          ready;
  logic [sdrs_pkg::TAG_BITS-1:0] out_tag;
  logic [sdrs_pkg::KEY_BITS-1:0] out_rating;
  logic                          last_out;
  logic                          overflow;

  modport source (output valid, output out_tag, output out_rating, output last_out,
                  output overflow, input ready);
  modport sink   (input valid, input out_tag, input out_rating, input last_out,
                  input overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/sdrs_cell.sv
// ----------------------------------------------------------------------------
// sdrs_cell
// One slot of the insertion chain: holds a record, keeps it, takes the new
// record, takes its upstream neighbor's record, or takes the downstream one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdrs_cell (
  input  wire logic           clk_i,
  input  wire sdrs_pkg::ctl_t ctl_i,
  input  wire logic           valid_i,      // slot holds a record of this list
  input  wire logic           prev_stay_i,  // upstream slot keeps its record
  input  wire sdrs_pkg::rec_t prev_rec_i,
  input  wire sdrs_pkg::rec_t next_rec_i,
  output sdrs_pkg::rec_t      rec_o,
  output logic                stay_o
);

  sdrs_pkg::rec_t rec_q, rec_d;

  // Equal ratings stay ahead of the newcomer: stable order
  assign stay_o = valid_i && (rec_q.rating >= ctl_i.new_rec.rating);

  always_comb begin
    rec_d = rec_q;
    priority if (ctl_i.shift) begin
      rec_d = next_rec_i;
    end else if (ctl_i.ins && !stay_o) begin
      rec_d = prev_stay_i ? ctl_i.new_rec : prev_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

`default_nettype wire

>>> rtl/stable_descending_record_sorter_unit.sv
// ----------------------------------------------------------------------------
// stable_descending_record_sorter_unit
// Stable descending insertion sorter built as a chain of record cells.
// ----------------------------------------------------------------------------
// Records arrive one per item and are kept sorted by rating, highest first;
// a record with a rating equal to stored ones lands behind them, so arrival
// order is kept among ties. While a list is being collected the block takes
// one record every cycle: every cell compares its rating against the new one
// in parallel and the tail of the chain moves down one slot in the same cycle.
// The item flagged last_in is inserted too, then the whole list streams out
// from the head cell, one item per cycle while the sink is ready, with
// last_out on the final one and overflow on every item of a list that lost
// records. During that output phase the input is held off (ready low), so the
// next list may start only once every stored record of this one has gone out.
// Capacity is sdrs_pkg::CAPACITY records; records arriving at a full
// store, the last one included, are dropped and only raise overflow. No
// clearing pass follows reset: the block is ready as soon as reset ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stable_descending_record_sorter_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sdrs_in_if.sink   in_i,
  sdrs_out_if.source out_o
);

  localparam int N = sdrs_pkg::CAPACITY;
  localparam int W = sdrs_pkg::CNT_W;

  sdrs_pkg::state_e       state_q, state_d;
  logic [W-1:0]           count_q, count_d;     // records held in the chain
  logic                   dropped_q, dropped_d; // this list lost records

  logic                   in_hs, out_hs, full;
  sdrs_pkg::ctl_t         ctl;

  sdrs_pkg::rec_t         rec   [N];
  logic                   stay  [N];

  assign in_hs  = in_i.valid && in_i.ready;
  assign out_hs = out_o.valid && out_o.ready;
  assign full   = (count_q == W'(N));

  // Broadcast control for the chain
  assign ctl.ins            = in_hs && !full;
  assign ctl.shift          = out_hs;
  assign ctl.new_rec.tag    = in_i.record_tag;
  assign ctl.new_rec.rating = in_i.rating_key;

  // Cell chain: cell 0 is the head (highest rating). Valid entries always
  // sit contiguously from the head, so validity is a compare with count.
  for (genvar i = 0; i < N; i++) begin : g_cell
    sdrs_pkg::rec_t prev_rec, next_rec;
    logic           prev_stay;

    if (i == 0) begin : g_head
      assign prev_rec  = ctl.new_rec;
      assign prev_stay = 1'b1;
    end else begin : g_body
      assign prev_rec  = rec[i-1];
      assign prev_stay = stay[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign next_rec = '0;
    end else begin : g_mid
      assign next_rec = rec[i+1];
    end

    sdrs_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (W'(i) < count_q),
      .prev_stay_i (prev_stay),
      .prev_rec_i  (prev_rec),
      .next_rec_i  (next_rec),
      .rec_o       (rec[i]),
      .stay_o      (stay[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdrs_pkg::ST_FILL: begin
        if (in_hs && in_i.last_in) state_d = sdrs_pkg::ST_DRAIN;
      end
      sdrs_pkg::ST_DRAIN: begin
        if (out_hs && (count_q == W'(1))) state_d = sdrs_pkg::ST_FILL;
      end
      default: state_d = sdrs_pkg::ST_FILL;
    endcase
  end

  // Count and overflow flag
  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (ctl.ins) count_d = count_q + W'(1);
    if (out_hs)  count_d = count_q - W'(1);
    if (in_hs && full) dropped_d = 1'b1;
    if (out_hs && (count_q == W'(1))) dropped_d = 1'b0;
  end

  // Channel outputs
  always_comb begin
    in_i.ready        = (state_q == sdrs_pkg::ST_FILL);
    out_o.valid       = (state_q == sdrs_pkg::ST_DRAIN);
    out_o.out_tag     = rec[0].tag;
    out_o.out_rating  = rec[0].rating;
    out_o.last_out    = (count_q == W'(1));
    out_o.overflow    = dropped_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sdrs_pkg::ST_FILL;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sdrs_checker.sv
// ----------------------------------------------------------------------------
// sdrs_checker
// Port-level checks of the record sorter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stable_descending_record_sorter_unit_defines.svh"

module sdrs_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [sdrs_pkg::KEY_BITS-1:0] out_rating_i,
  input wire logic                          last_out_i,
  input wire logic                          overflow_i
);

  logic out_hs;
  assign out_hs = out_valid_i && out_ready_i;

  // Stalled output holds its item
  `SDRS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_rating_i) && $stable(last_out_i), "stalled output item changed")

  // No record taken while a sorted list is streaming out
  `SDRS_ASSERT_NOW(a_no_in_during_out, out_valid_i, !in_ready_i, "input accepted during output")

  // The list ends exactly at last_out
  `SDRS_ASSERT_NEXT(a_end_of_list, out_hs && last_out_i, !out_valid_i, "output continued after last item")

  // Mid-list: output continues, overflow stays the same for the list
  `SDRS_ASSERT_NEXT(a_list_continues, out_hs && !last_out_i, out_valid_i && $stable(overflow_i), "list broken off or overflow changed mid-list")

  // Ratings never rise within a list
  `SDRS_ASSERT_NOW(a_descending, out_valid_i && $past(out_hs && !last_out_i), out_rating_i <= $past(out_rating_i), "ratings out of descending order")

endmodule

bind stable_descending_record_sorter_unit sdrs_checker u_sdrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_rating_i (out_o.out_rating),
  .last_out_i   (out_o.last_out),
  .overflow_i   (out_o.overflow)
);

`default_nettype wire

>>> sim/tb_stable_descending_record_sorter_unit.sv
// ----------------------------------------------------------------------------
// tb_stable_descending_record_sorter_unit
// Self-checking bench for the stable descending record sorter. A scoreboard
// keeps its own sorted copy of each list and checks every emitted item in
// order. Traffic is directed lists followed by random lists, with bursty
// input, a patterned output stall and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stable_descending_record_sorter_unit;

  // Field widths used for sizing random draws
  localparam int TAG_W = sdrs_pkg::TAG_BITS;
  localparam int KEY_W = sdrs_pkg::KEY_BITS;

  // Cycles the sink holds ready low once, during a full list's drain
  localparam int HOLD_CYCLES = 300;
  // Cycles with no item moving on either side before the run is declared hung
  localparam int IDLE_LIMIT  = 2000;
  // Settling time after the last expected item
  localparam int TAIL_CYCLES = 40;
  // Rough count of input items to offer
  localparam int ITEM_TARGET = 280;

  // Rating shapes for random lists
  typedef enum int {
    RATE_FULL,     // anywhere in the key range
    RATE_TIES,     // few distinct values, heavy ties
    RATE_EXTREMES, // only the minimum and maximum key
    RATE_TOP       // clustered at the top of the range
  } rate_mode_e;

  // One emitted item as predicted
  typedef struct packed {
    sdrs_pkg::rec_t rec;
    logic           last_out;
    logic           overflow;
  } emitted_t;

  // --------------------------------------------------------------------------
  // Scoreboard: sorted copy of the list being collected, queue of the items
  // the block owes once a list closes.
  // --------------------------------------------------------------------------
  class descending_list_board;
    sdrs_pkg::rec_t held [sdrs_pkg::CAPACITY];
    int             held_count;
    bit             lost;
    emitted_t       sorted_due [$];
    int             errors;

    function new();
      held_count = 0;
      lost       = 1'b0;
      errors     = 0;
    endfunction

    // Insert one accepted record; on the last one queue the whole sorted list
    function void note_record(sdrs_pkg::rec_t r, logic last);
      int       pos;
      emitted_t e;
      if (held_count >= sdrs_pkg::CAPACITY) begin
        lost = 1'b1;
      end else begin
        pos = 0;
        // Stable: skip past every stored record rated equal or higher
        while (pos < held_count && held[pos].rating >= r.rating) pos++;
        for (int j = held_count; j > pos; j--) held[j] = held[j-1];
        held[pos] = r;
        held_count++;
      end
      if (last) begin
        for (int k = 0; k < held_count; k++) begin
          e.rec      = held[k];
          e.last_out = (k == held_count - 1);
          e.overflow = lost;
          sorted_due.push_back(e);
        end
        held_count = 0;
        lost       = 1'b0;
      end
    endfunction

    function void check_emitted(logic [sdrs_pkg::TAG_BITS-1:0] tag,
                                logic [sdrs_pkg::KEY_BITS-1:0] rating,
                                logic last_out, logic overflow);
      emitted_t e;
      if (sorted_due.size() == 0) begin
        $error("unexpected item: out_tag %0d out_rating %0d", tag, rating);
        errors++;
        return;
      end
      e = sorted_due.pop_front();
      if (tag !== e.rec.tag) begin
        $error("out_tag: expected %0d, actual %0d", e.rec.tag, tag);
        errors++;
      end
      if (rating !== e.rec.rating) begin
        $error("out_rating: expected %0d, actual %0d", e.rec.rating, rating);
        errors++;
      end
      if (last_out !== e.last_out) begin
        $error("last_out: expected %0d, actual %0d", e.last_out, last_out);
        errors++;
      end
      if (overflow !== e.overflow) begin
        $error("overflow: expected %0d, actual %0d", e.overflow, overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sdrs_in_if  in_ch ();
  sdrs_out_if out_ch ();

  stable_descending_record_sorter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  descending_list_board board = new();

  // Sender burst state
  int burst_left = 0;
  bit gaps_on    = 1'b0;
  int items_sent = 0;

  // Set by the stimulus, taken and cleared by the sink process
  bit hold_req = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitors. Everything is driven with NBAs at the edge, so values read here
  // are the ones the block saw at this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        board.check_emitted(out_ch.out_tag, out_ch.out_rating, out_ch.last_out,
                            out_ch.overflow);
      if (in_ch.valid && in_ch.ready)
        board.note_record(sdrs_pkg::rec_t'{tag: in_ch.record_tag,
                                           rating: in_ch.rating_key},
                          in_ch.last_in);
    end
  end

  // Watchdog: any handshake on either side clears the idle count
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_stable_descending_record_sorter_unit: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink. Steps through four stall modes in turn; a hold request parks ready
  // low for HOLD_CYCLES so the drain stalls and the input backs up behind it.
  // --------------------------------------------------------------------------
  initial begin : sink_proc
    int cyc;
    cyc = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        case ((cyc / 50) % 4)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          2: out_ch.ready <= (cyc % 5 != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Always entered and left at a rising edge.
  // --------------------------------------------------------------------------
  task automatic offer_record(input logic [sdrs_pkg::TAG_BITS-1:0] tag,
                              input logic [sdrs_pkg::KEY_BITS-1:0] rating,
                              input logic last);
    int gap;
    in_ch.record_tag <= tag;
    in_ch.rating_key <= rating;
    in_ch.last_in    <= last;
    in_ch.valid      <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    // Bursts of random length; a gap only when gaps are enabled
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = $urandom_range(1, 12);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // One list of len records with random tags; hold_at_end asks the sink for
  // its long hold-off just before the closing record goes in
  task automatic offer_list(input int len, input rate_mode_e mode, input bit hold_at_end);
    logic [sdrs_pkg::KEY_BITS-1:0] rating;
    for (int i = 0; i < len; i++) begin
      case (mode)
        RATE_TIES:     rating = KEY_W'($urandom_range(0, 2));
        RATE_EXTREMES: rating = ($urandom_range(0, 1) == 1) ? '1 : '0;
        RATE_TOP:      rating = KEY_W'($urandom_range((1 << KEY_W) - 4, (1 << KEY_W) - 1));
        default:       rating = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
      endcase
      if (hold_at_end && i == len - 1) hold_req = 1'b1;
      offer_record(TAG_W'($urandom_range(0, (1 << TAG_W) - 1)), rating, i == len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_proc
    int         len;
    int         pick;
    rate_mode_e mode;

    in_ch.valid      <= 1'b0;
    in_ch.record_tag <= '0;
    in_ch.rating_key <= '0;
    in_ch.last_in    <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single-record lists at the field extremes
    offer_record(8'd255, 10'd1023, 1'b1);
    offer_record(8'd0,   10'd0,    1'b1);
    // All ties: arrival order must survive
    offer_record(8'd1, 10'd5, 1'b0);
    offer_record(8'd2, 10'd5, 1'b0);
    offer_record(8'd3, 10'd5, 1'b0);
    offer_record(8'd4, 10'd5, 1'b1);
    // Ascending arrivals come out reversed
    offer_record(8'd10, 10'd0,    1'b0);
    offer_record(8'd11, 10'd1,    1'b0);
    offer_record(8'd12, 10'd512,  1'b0);
    offer_record(8'd13, 10'd1023, 1'b1);
    // Already descending
    offer_record(8'd20, 10'd1023, 1'b0);
    offer_record(8'd21, 10'd700,  1'b0);
    offer_record(8'd22, 10'd1,    1'b1);
    // Interleaved mid-range ties, with both ends of the key range mixed in
    offer_record(8'd30, 10'd100,  1'b0);
    offer_record(8'd31, 10'd200,  1'b0);
    offer_record(8'd32, 10'd100,  1'b0);
    offer_record(8'd33, 10'd200,  1'b0);
    offer_record(8'd34, 10'd0,    1'b0);
    offer_record(8'd35, 10'd1023, 1'b0);
    offer_record(8'd36, 10'd100,  1'b1);
    // Alternating bit patterns
    offer_record(8'hAA, 10'h2AA, 1'b0);
    offer_record(8'h55, 10'h155, 1'b1);

    // Full list closed under a long sink hold-off; the following lists keep
    // pushing while the drain is parked
    gaps_on = 1'b0;
    offer_list(sdrs_pkg::CAPACITY, RATE_FULL, 1'b1);
    offer_list(6, RATE_TIES, 1'b0);
    // Store full with the closing record dropped
    offer_list(sdrs_pkg::CAPACITY + 1, RATE_TIES, 1'b0);

    // Random lists: mostly short, some exactly full, some overrunning
    while (items_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 11);
      if (pick == 0)      len = $urandom_range(sdrs_pkg::CAPACITY + 1, sdrs_pkg::CAPACITY + 8);
      else if (pick == 1) len = sdrs_pkg::CAPACITY;
      else                len = $urandom_range(1, 10);
      mode = rate_mode_e'($urandom_range(0, 3));
      offer_list(len, mode, 1'b0);
    end
    in_ch.valid <= 1'b0;

    // Let the monitor log the closing record before polling the queue
    @(posedge clk_i);
    while (board.sorted_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (board.errors == 0 && board.sorted_due.size() == 0) begin
      $display("tb_stable_descending_record_sorter_unit: done, clean");
    end else begin
      $display("tb_stable_descending_record_sorter_unit: done, errors");
    end
    $finish;
  end

endmodule
